### design/assert_macros.svh
// assertion macros shared by the prefix-sum tree modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### design/fpst_pkg.sv
// package for the prefix-sum tree: widths, codes, sequencer state and control structs
package fpst_pkg;

    localparam int TREE_SIZE_DEF = 1024;
    localparam int INDEX_W       = 10;
    localparam int DELTA_W       = 32;
    localparam int SUM_W         = 64;

    localparam logic CMD_ADD          = 1'b0;
    localparam logic CMD_QUERY        = 1'b1;
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } fpst_state_t;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic walk_live;
        logic clear_last;
        logic out_free;
    } fpst_stat_t;

    // strobes from the sequencer to the datapath
    typedef struct packed {
        logic in_ready;
        logic clear_en;
        logic walk_en;
        logic load_out;
    } fpst_ctrl_t;

endpackage

### design/fpst_seq.sv
// sequencer for the prefix-sum tree: clearing pass, accept, node walk, result hand-off
`include "assert_macros.svh"

module fpst_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fpst_pkg::fpst_stat_t stat,
    output fpst_pkg::fpst_ctrl_t ctrl
);

    fpst_pkg::fpst_state_t state_reg;
    fpst_pkg::fpst_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpst_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpst_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = fpst_pkg::ST_IDLE;
                end
            end
            fpst_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fpst_pkg::ST_WALK;
                end
            end
            fpst_pkg::ST_WALK:
            begin
                // last pending node is folded in during the final walk cycle
                if (!stat.walk_live)
                begin
                    state_next = fpst_pkg::ST_DONE;
                end
            end
            fpst_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = fpst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpst_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            fpst_pkg::ST_CLEAR: ctrl.clear_en = 1'b1;
            fpst_pkg::ST_IDLE:  ctrl.in_ready = 1'b1;
            fpst_pkg::ST_WALK:  ctrl.walk_en  = 1'b1;
            fpst_pkg::ST_DONE:  ctrl.load_out = stat.out_free;
            default:            ctrl = '0;
        endcase
    end

    `ASSERT_CLK(a_load_needs_free, clk, rst_n, ctrl.load_out |-> stat.out_free, "result loaded over a waiting word")
    `ASSERT_CLK(a_walk_ends, clk, rst_n, (ctrl.walk_en && !stat.walk_live) |=> (state_reg == fpst_pkg::ST_DONE), "walk did not end")
    `ASSERT_CLK(a_clear_exit, clk, rst_n, ctrl.clear_en |=> (ctrl.clear_en || ctrl.in_ready), "clearing pass left wrongly")

endmodule

### design/fenwick_prefix_sum_tree_core.sv
// prefix-sum tree top level: node memory, walk datapath with one shared 64-bit adder, output register
// an item is accepted, walks its nodes one by one, then its word is loaded into the output register
// one item at a time: in_ready is high only in idle, so a new item waits until the last word is loaded out
// the node memory read port paces the walk: one node is read per cycle, adds write back behind it
// reset: a clearing pass writes zero to all TREE_SIZE entries, one per cycle, in_ready low
// throughout; control registers clear asynchronously on rst_n low
`include "assert_macros.svh"

module fenwick_prefix_sum_tree_core #(
    parameter int TREE_SIZE = fpst_pkg::TREE_SIZE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [fpst_pkg::INDEX_W-1:0]     index,
    input  logic signed [fpst_pkg::DELTA_W-1:0] delta,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [fpst_pkg::SUM_W-1:0] prefix_sum,
    output logic                             status
);

    localparam int AW = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;
    localparam int PW = ((AW > fpst_pkg::INDEX_W) ? AW : fpst_pkg::INDEX_W) + 1;
    localparam int SW = fpst_pkg::SUM_W;
    localparam int DW = fpst_pkg::DELTA_W;
    localparam logic [PW-1:0] TREE_LIM  = PW'(TREE_SIZE);
    localparam logic [PW-1:0] TREE_LAST = PW'(TREE_SIZE - 1);
    localparam logic [AW-1:0] CLR_LAST  = AW'(TREE_SIZE - 1);

    fpst_pkg::fpst_ctrl_t ctrl;
    fpst_pkg::fpst_stat_t stat;

    logic [SW-1:0] node_mem [TREE_SIZE];

    logic [AW-1:0] clr_cnt_reg;
    logic [PW-1:0] pos_reg, pos_next;
    logic [AW-1:0] rd_addr_reg;
    logic          rd_vld_reg;
    logic [SW-1:0] rdata_reg;
    logic [SW-1:0] acc_reg;
    logic          cmd_reg;
    logic [DW-1:0] delta_reg;
    logic          status_reg;
    logic          out_valid_reg;
    logic [SW-1:0] prefix_sum_reg;
    logic          out_status_reg;

    logic [PW-1:0] index_ext;
    logic [PW-1:0] pos_start;
    logic [PW-1:0] low_bit;
    logic          walk_live;
    logic [SW-1:0] delta_ext;
    logic [SW-1:0] sum;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic          accept;

    fpst_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    assign accept    = in_valid && ctrl.in_ready;
    assign index_ext = PW'(index);

    // queries beyond the tree saturate to the last node
    assign pos_start = ((cmd == fpst_pkg::CMD_QUERY) && (index_ext >= TREE_LIM))
                       ? TREE_LAST : index_ext;

    assign low_bit   = pos_reg & (~pos_reg + PW'(1));
    assign walk_live = (pos_reg != '0) && ((cmd_reg == fpst_pkg::CMD_QUERY) || (pos_reg < TREE_LIM));
    assign pos_next  = (cmd_reg == fpst_pkg::CMD_QUERY) ? (pos_reg - low_bit) : (pos_reg + low_bit);

    // the one shared adder: node plus running sum for a query, node plus delta for an add
    assign delta_ext = {{(SW - DW){delta_reg[DW-1]}}, delta_reg};
    assign sum       = rdata_reg + ((cmd_reg == fpst_pkg::CMD_QUERY) ? acc_reg : delta_ext);

    assign mem_we    = ctrl.clear_en
                       || (ctrl.walk_en && rd_vld_reg && (cmd_reg == fpst_pkg::CMD_ADD));
    assign mem_waddr = ctrl.clear_en ? clr_cnt_reg : rd_addr_reg;
    assign mem_wdata = ctrl.clear_en ? '0 : sum;

    assign stat.walk_live  = walk_live;
    assign stat.clear_last = (clr_cnt_reg == CLR_LAST);
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= node_mem[pos_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            rd_vld_reg <= ctrl.walk_en && walk_live;
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            delta_reg  <= delta;
            pos_reg    <= pos_start;
            acc_reg    <= '0;
            status_reg <= ((cmd == fpst_pkg::CMD_ADD) && (index == '0))
                          ? fpst_pkg::STATUS_BAD_INDEX : fpst_pkg::STATUS_OK;
        end
        else if (ctrl.walk_en)
        begin
            if (walk_live)
            begin
                pos_reg     <= pos_next;
                rd_addr_reg <= pos_reg[AW-1:0];
            end
            if (rd_vld_reg && (cmd_reg == fpst_pkg::CMD_QUERY))
            begin
                acc_reg <= sum;
            end
        end
        if (ctrl.load_out)
        begin
            prefix_sum_reg <= (cmd_reg == fpst_pkg::CMD_QUERY) ? acc_reg : '0;
            out_status_reg <= status_reg;
        end
    end

    assign in_ready   = ctrl.in_ready;
    assign out_valid  = out_valid_reg;
    assign prefix_sum = prefix_sum_reg;
    assign status     = out_status_reg;

    `ASSERT_CLK(a_no_write_node0, clk, rst_n, (mem_we && !ctrl.clear_en) |-> (rd_addr_reg != '0), "add wrote node zero")
    `ASSERT_CLK(a_reject_zero_sum, clk, rst_n, (out_valid_reg && out_status_reg) |-> (prefix_sum_reg == '0), "rejected add gave a sum")
    `ASSERT_NEVER(a_no_write_idle, clk, rst_n, mem_we && ctrl.in_ready, "node memory written while idle")

endmodule
